FILE: rtl/core/sha256_pkg.sv
`timescale 1ns / 1ps
package sha256_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned Rounds = 64;
   localparam int unsigned DigestWords = 8;

   localparam logic [1:0] CMD_ABSORB = 2'd0;
   localparam logic [1:0] CMD_ABSORB_FINISH = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LENGTH_START = 6'd56;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_PAD,
      ST_OUT
   } state_type;

   localparam logic [31:0] ROUND_K [Rounds] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   localparam logic [31:0] INIT_HASH [DigestWords] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

endpackage

FILE: rtl/core/sha256_if.sv
`timescale 1ns / 1ps
interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data;
   modport source(output valid, command, data, input ready);
   modport sink(input valid, command, data, output ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last;
   modport source(output valid, digest_word, word_index, last, input ready);
   modport sink(input valid, digest_word, word_index, last, output ready);
endinterface

FILE: rtl/core/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// A byte that leaves the block partly full is accepted and ready stays high. A byte
// that fills the block keeps ready low while the schedule is loaded, the 64 rounds run
// and the hash is folded. A finish writes one padding byte per cycle up to the block end,
// compresses once or twice, then shows eight beats, one per cycle while the receiver is ready.
// Throughput: one round per cycle through the single shared round unit.
// Reset (synchronous, active high) restores the initial hash and an empty message.
module sha256_byte_stream_hasher (
   input logic clock,
   input logic reset,
   sha256_req_if.sink   req,
   sha256_rsp_if.source rsp
);
   import sha256_pkg::*;

   // The block buffer holds sixteen big-endian words. Bytes are written one per
   // cycle into their lane, and one word per cycle is read into a register
   // while the schedule is loaded.
   logic [31:0] buf_mem [BlockBytes / 4];
   logic [31:0] rd_ff;
   logic [31:0] hash_ff [DigestWords];
   logic [31:0] hash_in [DigestWords];
   logic [31:0] s_ff [DigestWords];
   logic [31:0] s_in [DigestWords];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [63:0] len_ff, len_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        fin_ff, fin_in;
   // Padding progress: pad byte written, pad byte landed too late for the
   // length, and the block now being compressed carries the length.
   logic        pad_ff, pad_in;
   logic        spill_ff, spill_in;
   logic        padded_ff, padded_in;
   state_type   state_ff, state_in;

   logic        wr_en;
   logic [7:0]  wr_byte;

   // Memory: byte write into the lane of the fill position, registered word read
   // at the load counter.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[fill_ff[5:2]][{~fill_ff[1:0], 3'd0} +: 8] <= wr_byte;
      end
      rd_ff <= buf_mem[cnt_ff[3:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         bits_ff   <= '0;
         cnt_ff    <= '0;
         fin_ff    <= 1'b0;
         pad_ff    <= 1'b0;
         spill_ff  <= 1'b0;
         padded_ff <= 1'b0;
         for (int i = 0; i < DigestWords; i++) hash_ff[i] <= INIT_HASH[i];
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         bits_ff   <= bits_in;
         cnt_ff    <= cnt_in;
         fin_ff    <= fin_in;
         pad_ff    <= pad_in;
         spill_ff  <= spill_in;
         padded_ff <= padded_in;
         hash_ff   <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff   <= s_in;
      w_ff   <= w_in;
      len_ff <= len_in;
   end

   // Shared round unit: one schedule step and one compression round.
   logic [31:0] w_new, t1, t2, sig0, sig1, x2, x15, e, a;
   logic [5:0]  rnd;
   always_comb begin
      rnd  = cnt_ff[5:0];
      x2   = w_ff[14];
      x15  = w_ff[1];
      sig1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
      sig0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
      // The window holds w[i-16..i-1] with the oldest at index 0.
      w_new = (rnd < 6'd16) ? w_ff[rnd[3:0]] : (w_ff[0] + sig0 + w_ff[9] + sig1);
      e  = s_ff[4];
      a  = s_ff[0];
      t1 = s_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & s_ff[5]) ^ (~e & s_ff[6]))
           + ROUND_K[rnd] + w_new;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & s_ff[1]) ^ (a & s_ff[2]) ^ (s_ff[1] & s_ff[2]));
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      bits_in   = bits_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      fin_in    = fin_ff;
      pad_in    = pad_ff;
      spill_in  = spill_ff;
      padded_in = padded_ff;
      hash_in   = hash_ff;
      s_in      = s_ff;
      w_in      = w_ff;
      wr_en     = 1'b0;
      wr_byte   = req.data;
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      rsp.digest_word = hash_ff[cnt_ff[2:0]];
      rsp.word_index  = cnt_ff[2:0];
      rsp.last        = (cnt_ff[2:0] == 3'(DigestWords - 1));
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               if (req.command == CMD_ABSORB || req.command == CMD_ABSORB_FINISH) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
                  fin_in  = (req.command == CMD_ABSORB_FINISH);
                  len_in  = bits_ff + 64'd8;
                  if (fill_ff == 6'(BlockBytes - 1)) begin
                     state_in = ST_LOAD;
                     cnt_in   = '0;
                  end else if (req.command == CMD_ABSORB_FINISH) begin
                     state_in = ST_PAD;
                     cnt_in   = '0;
                  end
               end else if (req.command == CMD_FINISH) begin
                  fin_in   = 1'b1;
                  len_in   = bits_ff;
                  state_in = ST_PAD;
                  cnt_in   = '0;
               end
            end
         end
         ST_PAD: begin
            // The pad byte goes first. A pad byte at offset 56 or later leaves no
            // room for the length, so the rest of that block is zero and the
            // length goes at the end of one more block.
            wr_en   = 1'b1;
            fill_in = fill_ff + 6'd1;
            if (!pad_ff) begin
               wr_byte  = PAD_BYTE;
               pad_in   = 1'b1;
               spill_in = (fill_ff >= LENGTH_START);
            end else if (fill_ff < LENGTH_START || spill_ff) begin
               wr_byte = 8'h00;
            end else begin
               wr_byte = len_ff[{3'd7 - fill_ff[2:0], 3'd0} +: 8];
            end
            if (fill_ff == 6'(BlockBytes - 1)) begin
               padded_in = pad_ff && !spill_ff;
               spill_in  = 1'b0;
               cnt_in    = '0;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // A word read issued on one cycle arrives on the next, so the window
            // shifts on load counts 1 through 16.
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff != 7'd0) begin
               for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
               w_in[15] = rd_ff;
            end
            if (cnt_ff == 7'd16) begin
               cnt_in   = '0;
               s_in     = hash_ff;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (rnd >= 6'd16) begin
               for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
               w_in[15] = w_new;
            end
            for (int i = 7; i > 0; i--) s_in[i] = s_ff[i - 1];
            s_in[4] = s_ff[3] + t1;
            s_in[0] = t1 + t2;
            cnt_in  = cnt_ff + 7'd1;
            // Count 64 is the fold cycle; the round unit output is unused there.
            if (cnt_ff == 7'(Rounds)) begin
               for (int i = 0; i < DigestWords; i++) hash_in[i] = hash_ff[i] + s_ff[i];
               s_in   = s_ff;
               w_in   = w_ff;
               cnt_in = '0;
               if (!fin_ff) begin
                  state_in = ST_IDLE;
               end else if (padded_ff) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_OUT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff[2:0] == 3'(DigestWords - 1)) begin
                  for (int i = 0; i < DigestWords; i++) hash_in[i] = INIT_HASH[i];
                  bits_in   = '0;
                  fill_in   = '0;
                  fin_in    = 1'b0;
                  pad_in    = 1'b0;
                  spill_in  = 1'b0;
                  padded_in = 1'b0;
                  cnt_in    = '0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_valid_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("result and request overlap");
   a_reset_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.last |=> bits_ff == 64'd0 && fill_ff == 6'd0)
      else $error("state not restored after digest");
`endif

endmodule
